@@ rtl/core/fsba_pkg.sv @@
// fsba_pkg: shared types and codes of the fenced slot bump allocator
// holds command and result word layouts, slot entry layout, opcodes and status codes
// no dependencies
package fsba_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd3;

    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_SEAL  = 3'd2;
    localparam logic [2:0] OP_ABORT = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_BUSY  = 3'd2;
    localparam logic [2:0] ST_TOKEN = 3'd3;
    localparam logic [2:0] ST_EXH   = 3'd4;

    localparam logic [1:0] PH_EMPTY  = 2'd0;
    localparam logic [1:0] PH_OPEN   = 2'd1;
    localparam logic [1:0] PH_SEALED = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  slot_sel;
        logic [63:0] token;
        logic        fence_done;
        logic [31:0] alloc_bytes;
        logic [4:0]  align_log2;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] cpu_addr;
        logic [63:0] dev_addr;
        logic [35:0] slice_offset;
        logic [31:0] slice_bytes;
        logic [31:0] used_bytes;
    } t_res;

    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] fill;
        logic [63:0] token;
    } t_slot_ent;

endpackage

@@ rtl/core/fsba_slot_store.sv @@
// fsba_slot_store: per-slot state memory with one write and one registered read port
// unwritten slots read as empty through per-slot valid flops cleared by reset
// depends on fsba_pkg
module fsba_slot_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  fsba_pkg::t_slot_ent   i_wr_ent,
    output fsba_pkg::t_slot_ent   o_rd_ent
);
    import fsba_pkg::*;

    t_slot_ent              r_mem [DEPTH];
    t_slot_ent              r_rd_ent;
    logic [DEPTH-1:0]       r_vld;
    logic                   r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_ent;
        end
        if (i_rd_en) begin
            r_rd_ent <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_vld[i_rd_addr];
            end
        end
    end

    // slot never written reads as empty, zero fill, zero token
    assign o_rd_ent = r_rd_hit ? r_rd_ent : '0;

`ifndef SYNTHESIS
    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_vld[$past(i_wr_addr)])
        else $error("written slot not marked valid");

    a_rd_after_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_rd_en && (i_wr_addr == i_rd_addr)) |=> 1'b0)
        else $error("read and write of the same slot in one cycle");

    a_empty_unwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rd_hit |-> (o_rd_ent.phase == PH_EMPTY))
        else $error("unwritten slot does not read as empty");
`endif

endmodule

@@ rtl/core/fenced_slot_bump_allocator.sv @@
// fenced_slot_bump_allocator: ring of slots with open/seal/fence tracking and bump allocation
// sequence: slot read, base add, then for alloc fill add, rounding, alignment and end sum,
// then decision, write-back and result strobe; busy stays high until the write-back,
// and the address chain runs one 64-bit add per cycle after the slot memory read
// reset: synchronous active low; all slots read empty at once through per-slot valid flops
// depends on fsba_pkg and fsba_slot_store
module fenced_slot_bump_allocator #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  fsba_pkg::t_cmd                    i_cmd,
    output logic                              o_res_valid,
    output fsba_pkg::t_res                    o_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fsba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);
    import fsba_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [8:0] MaxSlotsW = 9'(MAX_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_A1, S_A2, S_A3, S_A4, S_A5, S_FIN
    } t_state;

    t_state       r_state;
    logic         r_busy;
    logic         r_res_vld;
    t_res         r_res;
    t_cmd         r_cmd;
    logic         r_go;

    logic [63:0]  r_cpu_base;
    logic [63:0]  r_gpu_base;
    logic [4:0]   r_slot_count;
    logic [31:0]  r_slot_bytes;

    logic [39:0]  r_off;
    t_slot_ent    r_ent;
    logic [64:0]  r_sum1;
    logic [64:0]  r_sum2;
    logic [64:0]  r_sum3;
    logic [30:0]  r_mask;
    logic         r_ovf;
    logic [63:0]  r_aligned;
    logic [33:0]  r_local;
    logic [34:0]  r_end;
    logic [40:0]  r_soff;

    t_slot_ent    rd_ent;
    t_slot_ent    n_ent;
    logic         n_wr;
    t_res         n_res;
    logic         idx_ok;
    logic         op_ok;
    logic         accept;
    logic         cfg_wr;
    logic [63:0]  aligned;

    assign accept      = i_start && !r_busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !r_busy && !i_start;
    assign o_busy      = r_busy;
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

    assign idx_ok = ({3'b0, r_slot_count} > r_cmd.slot_sel)
                    && ({1'b0, r_cmd.slot_sel} < MaxSlotsW);
    assign op_ok  = (r_cmd.opcode == OP_BEGIN) || (r_cmd.opcode == OP_ALLOC)
                    || (r_cmd.opcode == OP_SEAL) || (r_cmd.opcode == OP_ABORT)
                    || (r_cmd.opcode == OP_QUERY);
    assign aligned = r_sum3[63:0] & ~{33'b0, r_mask};

    fsba_slot_store #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (r_cmd.slot_sel[AW-1:0]),
        .i_wr_en   (n_wr),
        .i_wr_addr (r_cmd.slot_sel[AW-1:0]),
        .i_wr_ent  (n_ent),
        .o_rd_ent  (rd_ent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_base   <= '0;
            r_gpu_base   <= '0;
            r_slot_count <= '0;
            r_slot_bytes <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_CPU_BASE:   r_cpu_base   <= i_cfg_data;
                CFG_GPU_BASE:   r_gpu_base   <= i_cfg_data;
                CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[4:0];
                CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // final decision and write-back of the slot entry
    always_comb begin
        n_ent        = r_ent;
        n_wr         = 1'b0;
        n_res        = '0;
        n_res.status = ST_PRE;
        if (r_state == S_FIN && r_go) begin
            case (r_cmd.opcode)
                OP_BEGIN: begin
                    if (r_ent.phase == PH_OPEN) begin
                        n_res.status = ST_BUSY;
                    end else if (r_ent.phase == PH_SEALED && !r_cmd.fence_done) begin
                        n_res.status = ST_BUSY;
                    end else if (r_ent.phase == PH_SEALED
                                 && (r_cmd.token == '0 || r_cmd.token != r_ent.token)) begin
                        n_res.status = ST_TOKEN;
                    end else begin
                        n_ent.phase  = PH_OPEN;
                        n_ent.fill   = '0;
                        n_ent.token  = '0;
                        n_wr         = 1'b1;
                        n_res.status = ST_OK;
                    end
                end
                OP_ALLOC: begin
                    if (r_cmd.alloc_bytes == '0) begin
                        n_res.status = ST_PRE;
                    end else if (r_ent.phase != PH_OPEN) begin
                        n_res.status = ST_BUSY;
                    end else if (r_ovf || (r_end > {3'b0, r_slot_bytes})) begin
                        n_res.status = ST_EXH;
                    end else begin
                        n_ent.fill         = r_end[31:0];
                        n_wr               = 1'b1;
                        n_res.status       = ST_OK;
                        n_res.cpu_addr     = r_aligned;
                        n_res.dev_addr     = r_gpu_base + {23'b0, r_soff};
                        n_res.slice_offset = r_soff[35:0];
                        n_res.slice_bytes  = r_cmd.alloc_bytes;
                    end
                end
                OP_SEAL: begin
                    if (r_cmd.token == '0) begin
                        n_res.status = ST_PRE;
                    end else if (r_ent.phase != PH_OPEN) begin
                        n_res.status = ST_BUSY;
                    end else begin
                        n_ent.phase  = PH_SEALED;
                        n_ent.token  = r_cmd.token;
                        n_wr         = 1'b1;
                        n_res.status = ST_OK;
                    end
                end
                OP_ABORT: begin
                    if (r_ent.phase != PH_OPEN) begin
                        n_res.status = ST_BUSY;
                    end else begin
                        n_ent.phase  = PH_EMPTY;
                        n_ent.fill   = '0;
                        n_wr         = 1'b1;
                        n_res.status = ST_OK;
                    end
                end
                default: begin
                    n_res.used_bytes = r_ent.fill;
                    n_res.status     = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_cmd;
                        r_busy  <= 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_go    <= idx_ok && op_ok;
                    r_off   <= {32'b0, r_cmd.slot_sel} * {8'b0, r_slot_bytes};
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_ent   <= rd_ent;
                    r_sum1  <= {1'b0, r_cpu_base} + {25'b0, r_off};
                    r_state <= (r_cmd.opcode == OP_ALLOC) ? S_A2 : S_FIN;
                end
                S_A2: begin
                    r_sum2  <= {1'b0, r_sum1[63:0]} + {33'b0, r_ent.fill};
                    r_ovf   <= r_sum1[64];
                    r_mask  <= 31'((32'd1 << r_cmd.align_log2) - 32'd1);
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_sum3  <= {1'b0, r_sum2[63:0]} + {34'b0, r_mask};
                    r_ovf   <= r_ovf || r_sum2[64];
                    r_state <= S_A4;
                end
                S_A4: begin
                    r_aligned <= aligned;
                    r_local   <= 34'(aligned - r_sum1[63:0]);
                    r_ovf     <= r_ovf || r_sum3[64];
                    r_state   <= S_A5;
                end
                S_A5: begin
                    r_end   <= {1'b0, r_local} + {3'b0, r_cmd.alloc_bytes};
                    r_soff  <= {1'b0, r_off} + {7'b0, r_local};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res     <= n_res;
                    r_res_vld <= 1'b1;
                    r_busy    <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!o_busy && $past(r_state == S_FIN)))
        else $error("result word outside the end of a command");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK)
        |-> (o_res.cpu_addr == '0 && o_res.slice_bytes == '0 && o_res.used_bytes == '0))
        else $error("failed command carries nonzero payload");

    a_alloc_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_wr && r_cmd.opcode == OP_ALLOC) |-> ({3'b0, n_ent.fill} <= {3'b0, r_slot_bytes}))
        else $error("alloc wrote a fill level past the slot size");

    a_no_write_if_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_wr |-> (r_go && n_res.status == ST_OK))
        else $error("slot written by a rejected command");
`endif

endmodule

@@ bench/fenced_slot_bump_allocator_tb.sv @@
// fenced_slot_bump_allocator_tb: self-checking bench for the fenced slot bump allocator
// a queue-fed driver sends command words, a monitor checks every result word against
// an in-bench prediction of slot phases, fill levels and fences; depends on fsba_pkg
module fenced_slot_bump_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsba_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        t_cmd        cmd;
        int unsigned gap;
    } t_pending;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start     = 1'b0;
    logic                 o_busy;
    t_cmd                 i_cmd       = '0;
    logic                 o_res_valid;
    t_res                 o_res;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;

    logic [63:0] ring_cpu_base;
    logic [63:0] ring_gpu_base;
    logic [4:0]  ring_slot_count;
    logic [31:0] ring_slot_bytes;
    logic [1:0]  phase_of [NUM_SLOTS];
    logic [31:0] fill_of  [NUM_SLOTS];
    logic [63:0] fence_of [NUM_SLOTS];

    t_pending    cmd_backlog[$];
    t_res        due_results[$];
    t_pending    head;
    logic        head_loaded = 1'b0;
    int unsigned idle_left   = 0;
    int unsigned n_err       = 0;
    int unsigned stall_cycles = 0;

    logic [63:0] seal_guess [NUM_SLOTS];
    int unsigned gen_live;
    logic [31:0] gen_bytes;
    logic        quiet_run   = 1'b0;
    int unsigned run_left    = 0;
    int unsigned words_queued = 0;

    fenced_slot_bump_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_res resolve_cmd(input t_cmd c);
        t_res        r;
        logic [4:0]  live;
        logic [3:0]  s;
        logic [63:0] offs;
        logic [63:0] mask;
        logic [63:0] aligned;
        logic [63:0] lcl;
        logic [64:0] sb;
        logic [64:0] sum_used;
        logic [64:0] sum_round;
        r = '0;
        r.status = ST_PRE;
        live = (ring_slot_count > NUM_SLOTS) ? 5'(NUM_SLOTS) : ring_slot_count;
        if (c.opcode > OP_QUERY || c.slot_sel >= live)
            return r;
        s = c.slot_sel[3:0];
        case (c.opcode)
            OP_BEGIN: begin
                if (phase_of[s] == PH_OPEN)
                    r.status = ST_BUSY;
                else if (phase_of[s] == PH_SEALED && !c.fence_done)
                    r.status = ST_BUSY;
                else if (phase_of[s] == PH_SEALED && (c.token == 64'd0 || c.token != fence_of[s]))
                    r.status = ST_TOKEN;
                else begin
                    fill_of[s]  = '0;
                    fence_of[s] = '0;
                    phase_of[s] = PH_OPEN;
                    r.status    = ST_OK;
                end
            end
            OP_ALLOC: begin
                if (c.alloc_bytes == 32'd0)
                    r.status = ST_PRE;
                else if (phase_of[s] != PH_OPEN)
                    r.status = ST_BUSY;
                else begin
                    offs      = 64'(s) * 64'(ring_slot_bytes);
                    sb        = {1'b0, ring_cpu_base} + {1'b0, offs};
                    mask      = (64'd1 << c.align_log2) - 64'd1;
                    sum_used  = sb + 65'(fill_of[s]);
                    sum_round = sum_used + 65'(mask);
                    if (sb[64] || sum_used[64] || sum_round[64])
                        r.status = ST_EXH;
                    else begin
                        aligned = sum_round[63:0] & ~mask;
                        lcl     = aligned - sb[63:0];
                        if (lcl > 64'(ring_slot_bytes)
                                || 64'(c.alloc_bytes) > 64'(ring_slot_bytes) - lcl)
                            r.status = ST_EXH;
                        else begin
                            fill_of[s]     = 32'(lcl + 64'(c.alloc_bytes));
                            r.status       = ST_OK;
                            r.cpu_addr     = aligned;
                            r.slice_offset = 36'(offs + lcl);
                            r.dev_addr     = ring_gpu_base + offs + lcl;
                            r.slice_bytes  = c.alloc_bytes;
                        end
                    end
                end
            end
            OP_SEAL: begin
                if (c.token == 64'd0)
                    r.status = ST_PRE;
                else if (phase_of[s] != PH_OPEN)
                    r.status = ST_BUSY;
                else begin
                    fence_of[s] = c.token;
                    phase_of[s] = PH_SEALED;
                    r.status    = ST_OK;
                end
            end
            OP_ABORT: begin
                if (phase_of[s] != PH_OPEN)
                    r.status = ST_BUSY;
                else begin
                    fill_of[s]  = '0;
                    phase_of[s] = PH_EMPTY;
                    r.status    = ST_OK;
                end
            end
            OP_QUERY: begin
                r.used_bytes = fill_of[s];
                r.status     = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: one command word per handshake, optional idle cycles before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start     <= 1'b0;
            head_loaded = 1'b0;
            idle_left   = 0;
        end else begin
            if (i_start && !o_busy)
                due_results.push_back(resolve_cmd(i_cmd));
            if (!i_start || !o_busy) begin
                if (!head_loaded && cmd_backlog.size() != 0) begin
                    head        = cmd_backlog.pop_front();
                    head_loaded = 1'b1;
                    idle_left   = head.gap;
                end
                if (head_loaded && idle_left == 0) begin
                    i_start     <= 1'b1;
                    i_cmd       <= head.cmd;
                    head_loaded = 1'b0;
                end else begin
                    i_start <= 1'b0;
                    if (head_loaded)
                        idle_left--;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (due_results.size() == 0) begin
                $error("result word with no command outstanding");
                n_err++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 64'(want.status), 64'(o_res.status));
                check_field("cpu_addr", want.cpu_addr, o_res.cpu_addr);
                check_field("dev_addr", want.dev_addr, o_res.dev_addr);
                check_field("slice_offset", 64'(want.slice_offset), 64'(o_res.slice_offset));
                check_field("slice_bytes", 64'(want.slice_bytes), 64'(o_res.slice_bytes));
                check_field("used_bytes", 64'(want.used_bytes), 64'(o_res.used_bytes));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic t_cmd mk_cmd(input logic [2:0] op, input logic [7:0] idx,
                                    input logic [63:0] tok, input logic proven,
                                    input logic [31:0] nbytes, input logic [4:0] lg);
        t_cmd c;
        c.opcode      = op;
        c.slot_sel    = idx;
        c.token       = tok;
        c.fence_done  = proven;
        c.alloc_bytes = nbytes;
        c.align_log2  = lg;
        return c;
    endfunction

    function automatic logic [63:0] rand_tok();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_slot();
        if (gen_live != 0 && $urandom_range(0, 99) < 88)
            return 8'($urandom_range(0, gen_live - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return gen_bytes;
            default: return $urandom_range(1, (gen_bytes >> 3) + 1);
        endcase
    endfunction

    function automatic logic [4:0] rand_align();
        if ($urandom_range(0, 4) != 0)
            return 5'($urandom_range(0, 6));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic push_word(input t_cmd c);
        t_pending p;
        if (run_left == 0) begin
            quiet_run = ($urandom_range(0, 2) == 0);
            run_left  = $urandom_range(10, 60);
        end
        run_left--;
        p.cmd = c;
        p.gap = quiet_run ? 0 : $urandom_range(0, 9);
        cmd_backlog.push_back(p);
        words_queued++;
    endtask

    // begin, a few allocs, maybe a query, then seal or abort on one slot
    task automatic push_slot_life();
        logic [7:0]  idx;
        logic [3:0]  s;
        logic [63:0] tok;
        idx = pick_slot();
        s   = idx[3:0];
        tok = ($urandom_range(0, 9) != 0) ? seal_guess[s] : rand_tok();
        push_word(mk_cmd(OP_BEGIN, idx, tok, $urandom_range(0, 9) != 0, $urandom,
                         5'($urandom)));
        repeat ($urandom_range(1, 6))
            push_word(mk_cmd(OP_ALLOC, idx, rand_tok(), 1'($urandom), rand_size(),
                             rand_align()));
        if ($urandom_range(0, 1) != 0)
            push_word(mk_cmd(OP_QUERY, idx, rand_tok(), 1'($urandom), $urandom,
                             5'($urandom)));
        if ($urandom_range(0, 4) != 0) begin
            tok = rand_tok();
            seal_guess[s] = tok;
            push_word(mk_cmd(OP_SEAL, idx, tok, 1'($urandom), $urandom, 5'($urandom)));
        end else
            push_word(mk_cmd(OP_ABORT, idx, rand_tok(), 1'($urandom), $urandom,
                             5'($urandom)));
    endtask

    task automatic push_noise();
        logic [63:0] tok;
        logic [31:0] nbytes;
        tok    = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_tok();
        nbytes = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_size();
        push_word(mk_cmd(3'($urandom_range(0, 7)), pick_slot(), tok, 1'($urandom), nbytes,
                         rand_align()));
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (cmd_backlog.size() != 0 || head_loaded || i_start || due_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CPU_BASE:   ring_cpu_base   = data;
            CFG_GPU_BASE:   ring_gpu_base   = data;
            CFG_SLOT_COUNT: ring_slot_count = data[4:0];
            CFG_SLOT_BYTES: ring_slot_bytes = data[31:0];
            default: ;
        endcase
    endtask

    task automatic set_ring(input logic [63:0] cpu, input logic [63:0] gpu,
                            input logic [4:0] cnt, input logic [31:0] nbytes);
        write_reg(CFG_CPU_BASE, cpu);
        write_reg(CFG_GPU_BASE, gpu);
        write_reg(CFG_SLOT_COUNT, 64'(cnt));
        write_reg(CFG_SLOT_BYTES, 64'(nbytes));
        gen_live  = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
        gen_bytes = nbytes;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [63:0] cpu, input logic [63:0] gpu,
                             input logic [4:0] cnt, input logic [31:0] nbytes,
                             input int unsigned len);
        int unsigned goal;
        logic        paused;
        drain();
        set_ring(cpu, gpu, cnt, nbytes);
        goal   = words_queued + len;
        paused = 1'b0;
        while (words_queued < goal) begin
            // once, halfway through the phase, the sender holds off until every result word is back
            if (!paused && words_queued + len / 2 >= goal) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                push_slot_life();
            else
                push_noise();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        ring_cpu_base   = '0;
        ring_gpu_base   = '0;
        ring_slot_count = '0;
        ring_slot_bytes = '0;
        gen_live        = 0;
        gen_bytes       = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            phase_of[k]   = PH_EMPTY;
            fill_of[k]    = '0;
            fence_of[k]   = '0;
            seal_guess[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ring not set up
        push_word(mk_cmd(OP_QUERY, 8'd0, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_BEGIN, 8'd0, '0, 1'b1, '0, '0));
        drain();

        set_ring(64'h0000_0040_0000_0000, 64'h0000_0080_0000_0010, 5'd4, 32'd4096);
        push_word(mk_cmd(OP_BEGIN, 8'd0, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_BEGIN, 8'd0, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_ALLOC, 8'd0, '0, 1'b0, 32'd0, '0));
        push_word(mk_cmd(OP_ALLOC, 8'd0, '0, 1'b0, 32'd100, 5'd0));
        push_word(mk_cmd(OP_ALLOC, 8'd0, '0, 1'b0, 32'd1, 5'd4));
        push_word(mk_cmd(OP_ALLOC, 8'd0, '0, 1'b0, 32'hFFFF_FFFF, 5'd31));
        push_word(mk_cmd(OP_ALLOC, 8'd0, '0, 1'b0, 32'd3983, 5'd0));
        push_word(mk_cmd(OP_QUERY, 8'd0, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_SEAL, 8'd0, 64'd0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_SEAL, 8'd0, '1, 1'b0, '0, '0));
        push_word(mk_cmd(OP_ALLOC, 8'd0, '0, 1'b0, 32'd8, 5'd0));
        push_word(mk_cmd(OP_BEGIN, 8'd0, '1, 1'b0, '0, '0));
        push_word(mk_cmd(OP_BEGIN, 8'd0, 64'd0, 1'b1, '0, '0));
        push_word(mk_cmd(OP_BEGIN, 8'd0, 64'd1, 1'b1, '0, '0));
        push_word(mk_cmd(OP_BEGIN, 8'd0, '1, 1'b1, '0, '0));
        push_word(mk_cmd(OP_ABORT, 8'd0, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_ABORT, 8'd0, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_SEAL, 8'd1, 64'd5, 1'b0, '0, '0));
        push_word(mk_cmd(OP_QUERY, 8'd255, '0, 1'b0, '0, '0));
        push_word(mk_cmd(OP_BEGIN, 8'd4, '0, 1'b0, '0, '0));
        for (int op = OP_QUERY + 1; op < 8; op++)
            push_word(mk_cmd(3'(op), 8'd3, '1, 1'b1, '1, '1));

        run_phase(rand_tok() & 64'h0000_FFFF_FFFF_F000, rand_tok(), 5'd4, 32'd4096, 300);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF - 64'd808, '1, 5'd8, 32'd256, 200);
        run_phase('0, '0, 5'd16, 32'hFFFF_FFFF, 200);
        run_phase(rand_tok(), rand_tok(), 5'd1, 32'd0, 80);
        run_phase(rand_tok() & 64'h0000_FFFF_FFFF_FFC0, rand_tok(), 5'd20, 32'd64, 200);
        run_phase(64'h1000, 64'h2000, 5'd4, 32'd16, 150);
        run_phase(rand_tok(), rand_tok(), 5'd0, 32'd1024, 40);
        run_phase('1, rand_tok(), 5'd2, 32'd1024, 280);
        drain();
        repeat (20) @(posedge i_clk);

        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fsba_pkg.sv
rtl/core/fsba_slot_store.sv
rtl/core/fenced_slot_bump_allocator.sv
bench/fenced_slot_bump_allocator_tb.sv
